// ----- hw/rtl/chunked_rotate_fnv_hash_macros.svh -----
// Assertion macros for the chunked rotate FNV hash checker.
// Clock and reset are passed in; no other dependencies.
`ifndef CHUNKED_ROTATE_FNV_HASH_MACROS_SVH
`define CHUNKED_ROTATE_FNV_HASH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRFH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("crfh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("crfh assertion failed");

`endif

// ----- hw/rtl/crfh_pkg.sv -----
// Package for the chunked rotate FNV hash block.
// Holds hash constants and stream widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crfh_pkg;

  localparam int unsigned HashW     = 64;
  localparam int unsigned CountW    = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BytesPerW = HashW / ByteW;
  localparam int unsigned IdxW      = $clog2(BytesPerW);
  localparam int unsigned InDataW   = ((HashW + CountW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = HashW;
  localparam int unsigned RotLeft   = 5;
  localparam int unsigned HighHalf  = 32;

  localparam logic [HashW-1:0] HashBasis = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HashW-1:0] HashPrime = 64'h0000_0100_0000_01B3;

endpackage

`default_nettype wire

// ----- hw/rtl/chunked_rotate_fnv_hash.sv -----
// Streaming hash over little-endian 64-bit words, a chunked FNV-1a 64 variant.
// A full 8-byte word is mixed in whole by the shared multiplier; a word that ends the
// message then waits for the result slot. A short final word of n bytes is hashed one
// byte per cycle through the single constant-prime multiplier, which is the unit every
// hashing step of the sequencer shares. Results sit in an output register, so a new item
// is taken while a finished hash waits there.
// Depends on crfh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chunked_rotate_fnv_hash
  import crfh_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [InDataW-1:0]   s_axis_tdata,  // [63:0] word_data, [67:64] byte_count, zero fill
  input  wire                 s_axis_tlast,  // end_of_message
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // [63:0] hash_value
);

  typedef enum logic [1:0] {
    StIdle,
    StBusy,
    StEmit
  } state_e;

  state_e             state_q;
  logic [HashW-1:0]   hash_q;
  logic [HashW-1:0]   word_q;
  logic [IdxW-1:0]    cnt_q;
  logic [IdxW-1:0]    num_q;
  logic               full_q;
  logic               eom_q;
  logic [OutDataW-1:0] out_q;
  logic               out_vld_q;

  logic               accept;
  logic               slot_free;
  logic [HashW-1:0]   mix;
  logic [HashW-1:0]   mul_in;
  logic [HashW-1:0]   mul_out;
  logic [ByteW-1:0]   cur_byte;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // Shared unit: operand select, then constant-prime multiply.
  assign cur_byte = word_q[{cnt_q, 3'b000} +: ByteW];
  assign mix      = hash_q ^ word_q;

  always_comb begin
    if (full_q) begin
      mul_in = {mix[HashW-RotLeft-1:0], mix[HashW-1:HashW-RotLeft]};
    end else begin
      mul_in = hash_q ^ {{(HashW-ByteW){1'b0}}, cur_byte};
    end
  end

  // Prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1: shift-add tree.
  assign mul_out = ((mul_in << 40) + (mul_in << 8)) + ((mul_in << 7) + (mul_in << 5))
                 + (((mul_in << 4) + (mul_in << 1)) + mul_in);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      hash_q    <= HashBasis;
      word_q    <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      num_q     <= '0;
      full_q    <= 1'b0;
      eom_q     <= 1'b0;
    end else begin
      if (slot_free) begin
        out_vld_q <= (state_q == StEmit);
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            word_q  <= s_axis_tdata[HashW-1:0];
            full_q  <= s_axis_tdata[HashW+CountW-1];
            num_q   <= s_axis_tdata[HashW+IdxW-1:HashW];
            eom_q   <= s_axis_tlast;
            cnt_q   <= '0;
            state_q <= StBusy;
          end
        end
        StBusy: begin
          if (full_q) begin
            hash_q  <= mul_out ^ {{(HashW-HighHalf){1'b0}}, word_q[HashW-1:HighHalf]};
            state_q <= eom_q ? StEmit : StIdle;
          end else if (cnt_q != num_q) begin
            hash_q <= mul_out;
            cnt_q  <= cnt_q + 1'b1;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (slot_free) begin
            out_q     <= hash_q;
            hash_q    <= HashBasis;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/crfh_checker.sv -----
// Port-level checker for the chunked rotate FNV hash block, bound to the top level.
// Depends on crfh_pkg and chunked_rotate_fnv_hash_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "chunked_rotate_fnv_hash_macros.svh"

module crfh_checker
  import crfh_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 s_axis_tvalid,
  input wire                 s_axis_tready,
  input wire [InDataW-1:0]   s_axis_tdata,  // [63:0] word_data, [67:64] byte_count, zero fill
  input wire                 s_axis_tlast,  // end_of_message
  input wire                 m_axis_tvalid,
  input wire                 m_axis_tready,
  input wire [OutDataW-1:0]  m_axis_tdata   // [63:0] hash_value
);

  logic s_acc;
  logic full_mid;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign full_mid = s_acc && s_axis_tdata[HashW+CountW-1] && !s_axis_tlast;

  `CRFH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `CRFH_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_acc, !s_axis_tready)
  `CRFH_ASSERT_NEXT(a_full_word_rate, clk_i, rst_ni, full_mid, ##1 s_axis_tready)
  `CRFH_ASSERT_IMPLY(a_result_from_work, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind chunked_rotate_fnv_hash crfh_checker u_crfh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
